// ===== hdl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  // fixed port field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned COL_FW = 7;
  localparam int unsigned ROW_FW = 5;
  localparam int unsigned POS_FW = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_SET   = 2'd3;

  // control characters
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h0F;
  localparam int unsigned       TAB_STEP   = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] code;
  } cell_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_lin_unit.sv =====
// Shared linear address unit: row * Columns + col.
// Depends on tcw_pkg for the default geometry.
`timescale 1ns / 1ps
`default_nettype none

module tcw_lin_unit #(
  parameter int unsigned Columns = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned Rows    = tcw_pkg::DEF_ROWS
) (
  input  wire logic [$clog2(Rows+1)-1:0]     row_i,
  input  wire logic [$clog2(Columns)-1:0]    col_i,
  output logic      [$clog2(Columns*Rows)-1:0] lin_o
);
  import tcw_pkg::*;

  localparam int unsigned AddrW = $clog2(Columns * Rows);

  // constant multiplier plus one add
  assign lin_o = AddrW'(32'(row_i) * Columns + 32'(col_i));

endmodule

`default_nettype wire

// ===== hdl/tcw_cell_ram.sv =====
// Character/attribute cell store: one write port, one registered read port.
// Depends on tcw_pkg for the cell type.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
  parameter int unsigned Depth = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire tcw_pkg::cell_t           wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output tcw_pkg::cell_t                rdata_o
);
  import tcw_pkg::*;

  cell_t mem_q [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tcw_seq.sv =====
// Sequencer of the text console writer: cursor logic, scroll/fill sweeps,
// and the cell store access. Depends on tcw_pkg and tcw_lin_unit.
`timescale 1ns / 1ps
`default_nettype none

module tcw_seq #(
  parameter int unsigned Columns = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned Rows    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tcw_pkg::OP_W-1:0]        op_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0]      char_code_i,
  input  wire logic [tcw_pkg::COL_FW-1:0]      col_i,
  input  wire logic [tcw_pkg::ROW_FW-1:0]      row_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0]      text_attr_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [tcw_pkg::BYTE_W-1:0]      read_char_o,
  output logic      [tcw_pkg::BYTE_W-1:0]      read_attr_o,
  output logic      [tcw_pkg::COL_FW-1:0]      cursor_col_o,
  output logic      [tcw_pkg::ROW_FW-1:0]      cursor_row_o,
  output logic      [tcw_pkg::POS_FW-1:0]      cursor_pos_o,
  output logic                                 mem_we_o,
  output logic      [$clog2(Columns*Rows)-1:0] mem_waddr_o,
  output tcw_pkg::cell_t                       mem_wdata_o,
  output logic      [$clog2(Columns*Rows)-1:0] mem_raddr_o,
  input  wire tcw_pkg::cell_t                  mem_rdata_i
);
  import tcw_pkg::*;

  localparam int unsigned Cells = Columns * Rows;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned ColW  = $clog2(Columns);
  localparam int unsigned RowW  = $clog2(Rows + 1);
  localparam int unsigned MoveN = (Rows - 1) * Columns;

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StIdle   = 4'd0;
  localparam logic [StW-1:0] StMove   = 4'd1;
  localparam logic [StW-1:0] StAddr   = 4'd2;
  localparam logic [StW-1:0] StAct    = 4'd3;
  localparam logic [StW-1:0] StRdWait = 4'd4;
  localparam logic [StW-1:0] StChk    = 4'd5;
  localparam logic [StW-1:0] StScroll = 4'd6;
  localparam logic [StW-1:0] StFill   = 4'd7;
  localparam logic [StW-1:0] StPos    = 4'd8;
  localparam logic [StW-1:0] StOut    = 4'd9;

  // control state
  logic [StW-1:0]    state_q, state_d;
  logic [ColW-1:0]   cur_col_q, cur_col_d;
  logic [RowW-1:0]   cur_row_q, cur_row_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] fill_attr_q, fill_attr_d;
  logic              fill_reply_q, fill_reply_d;
  logic              wr_pend_q, wr_pend_d;

  // payload
  logic [OP_W-1:0]   op_q, op_d;
  logic [BYTE_W-1:0] ch_q, ch_d;
  logic [COL_FW-1:0] col_in_q, col_in_d;
  logic [ROW_FW-1:0] row_in_q, row_in_d;
  logic [ColW-1:0]   tgt_col_q, tgt_col_d;
  logic [RowW-1:0]   tgt_row_q, tgt_row_d;
  logic [BYTE_W-1:0] wchar_q, wchar_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;
  logic [BYTE_W-1:0] rd_char_q, rd_char_d;
  logic [BYTE_W-1:0] rd_attr_q, rd_attr_d;
  logic [AddrW-1:0]  pos_q, pos_d;

  // shared address unit
  logic [RowW-1:0]  lin_row;
  logic [ColW-1:0]  lin_col;
  logic [AddrW-1:0] lin;

  logic [ColW:0]    col_inc;
  logic [ColW:0]    tab_col;
  logic [RowW-1:0]  row_inc;
  logic [ColW-1:0]  clamp_col;
  logic [RowW-1:0]  clamp_row;

  assign lin_row = (state_q == StPos) ? cur_row_q : tgt_row_q;
  assign lin_col = (state_q == StPos) ? cur_col_q : tgt_col_q;

  tcw_lin_unit #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_lin (
    .row_i (lin_row),
    .col_i (lin_col),
    .lin_o (lin)
  );

  assign col_inc = {1'b0, cur_col_q} + (ColW+1)'(1);
  assign tab_col = ({1'b0, cur_col_q} + (ColW+1)'(TAB_STEP)) & ~(ColW+1)'(TAB_STEP - 1);
  assign row_inc = cur_row_q + RowW'(1);

  assign clamp_col = (32'(col_in_q) < Columns) ? ColW'(col_in_q) : ColW'(Columns - 1);
  assign clamp_row = (32'(row_in_q) < Rows) ? RowW'(row_in_q) : RowW'(Rows - 1);

  always_comb begin
    state_d      = state_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    cnt_d        = cnt_q;
    fill_attr_d  = fill_attr_q;
    fill_reply_d = fill_reply_q;
    op_d         = op_q;
    ch_d         = ch_q;
    col_in_d     = col_in_q;
    row_in_d     = row_in_q;
    tgt_col_d    = tgt_col_q;
    tgt_row_d    = tgt_row_q;
    wchar_d      = wchar_q;
    idx_d        = idx_q;
    rd_char_d    = rd_char_q;
    rd_attr_d    = rd_attr_q;
    pos_d        = pos_q;
    // scroll copy: each cell's write comes in the cycle after its read
    wr_pend_d    = (state_q == StScroll) && (cnt_q != AddrW'(MoveN));
    wr_addr_d    = cnt_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = '{attr: text_attr_i, code: wchar_q};
    mem_raddr_o = (state_q == StScroll) ? cnt_q + AddrW'(Columns) : idx_q;

    if (wr_pend_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wr_addr_q;
      mem_wdata_o = mem_rdata_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d     = op_i;
          ch_d     = char_code_i;
          col_in_d = col_i;
          row_in_d = row_i;
          state_d  = StMove;
        end
      end
      StMove: begin
        rd_char_d = '0;
        rd_attr_d = '0;
        unique case (op_q)
          OP_PUT: begin
            priority if (ch_q == CH_NL) begin
              cur_col_d = '0;
              cur_row_d = row_inc;
              state_d   = StChk;
            end else if (ch_q == CH_CR) begin
              cur_col_d = '0;
              state_d   = StChk;
            end else if (ch_q == CH_TAB) begin
              if (32'(tab_col) >= Columns) begin
                cur_col_d = '0;
                cur_row_d = row_inc;
              end else begin
                cur_col_d = ColW'(tab_col);
              end
              state_d = StChk;
            end else if (ch_q == CH_BS) begin
              // step back, crossing to the previous row; origin stays put
              tgt_col_d = cur_col_q;
              tgt_row_d = cur_row_q;
              if (cur_col_q != '0) begin
                tgt_col_d = cur_col_q - ColW'(1);
              end else if (cur_row_q != '0) begin
                tgt_col_d = ColW'(Columns - 1);
                tgt_row_d = cur_row_q - RowW'(1);
              end
              cur_col_d = tgt_col_d;
              cur_row_d = tgt_row_d;
              wchar_d   = BLANK_CHAR;
              state_d   = StAddr;
            end else begin
              tgt_col_d = cur_col_q;
              tgt_row_d = cur_row_q;
              wchar_d   = ch_q;
              if (32'(col_inc) >= Columns) begin
                cur_col_d = '0;
                cur_row_d = row_inc;
              end else begin
                cur_col_d = ColW'(col_inc);
              end
              state_d = StAddr;
            end
          end
          OP_READ: begin
            tgt_col_d = clamp_col;
            tgt_row_d = clamp_row;
            state_d   = StAddr;
          end
          OP_CLEAR: begin
            cur_col_d    = '0;
            cur_row_d    = '0;
            cnt_d        = '0;
            fill_attr_d  = text_attr_i;
            fill_reply_d = 1'b1;
            state_d      = StFill;
          end
          OP_SET: begin
            cur_col_d = clamp_col;
            cur_row_d = clamp_row;
            state_d   = StPos;
          end
          default: ;
        endcase
      end
      StAddr: begin
        idx_d   = lin;
        state_d = StAct;
      end
      StAct: begin
        if (op_q == OP_READ) begin
          state_d = StRdWait;
        end else begin
          mem_we_o = 1'b1;
          state_d  = StChk;
        end
      end
      StRdWait: begin
        rd_char_d = mem_rdata_i.code;
        rd_attr_d = mem_rdata_i.attr;
        state_d   = StPos;
      end
      StChk: begin
        if (32'(cur_row_q) >= Rows) begin
          cnt_d   = '0;
          state_d = StScroll;
        end else begin
          state_d = StPos;
        end
      end
      StScroll: begin
        if (cnt_q == AddrW'(MoveN)) begin
          cur_row_d    = RowW'(Rows - 1);
          fill_attr_d  = text_attr_i;
          fill_reply_d = 1'b1;
          state_d      = StFill;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      StFill: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = '{attr: fill_attr_q, code: BLANK_CHAR};
        if (cnt_q == AddrW'(Cells - 1)) begin
          state_d = fill_reply_q ? StPos : StIdle;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      StPos: begin
        pos_d   = lin;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // reset starts with a clearing pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StFill;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      cnt_q        <= '0;
      fill_attr_q  <= RESET_ATTR;
      fill_reply_q <= 1'b0;
      wr_pend_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      cnt_q        <= cnt_d;
      fill_attr_q  <= fill_attr_d;
      fill_reply_q <= fill_reply_d;
      wr_pend_q    <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ch_q      <= ch_d;
    col_in_q  <= col_in_d;
    row_in_q  <= row_in_d;
    tgt_col_q <= tgt_col_d;
    tgt_row_q <= tgt_row_d;
    wchar_q   <= wchar_d;
    idx_q     <= idx_d;
    wr_addr_q <= wr_addr_d;
    rd_char_q <= rd_char_d;
    rd_attr_q <= rd_attr_d;
    pos_q     <= pos_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = (state_q == StOut);
  assign read_char_o  = rd_char_q;
  assign read_attr_o  = rd_attr_q;
  assign cursor_col_o = COL_FW'(cur_col_q);
  assign cursor_row_o = ROW_FW'(cur_row_q);
  assign cursor_pos_o = POS_FW'(pos_q);

endmodule

`default_nettype wire

// ===== hdl/text_console_writer_unit.sv =====
// Text console writer top level: attribute register, sequencer, cell store.
// Depends on tcw_pkg, tcw_seq, tcw_cell_ram.
//
// Usage:
//  - Input channel (in_valid_i/in_stall_o) takes one word: op, char_code,
//    col, row. Output channel (out_valid_o/out_stall_i) returns one word per
//    input: read cell data (zero unless a read) and the cursor after the op.
//  - cfg_we_i writes cfg_wdata_i into the text attribute (reset 0x0F); write
//    only while the block is idle.
//  - One word in flight: in_stall_o stays high from acceptance until the
//    result word is taken. States to out_valid_o: set cursor Move, Pos;
//    newline/return/tab Move, Chk, Pos; printable/backspace Move, Addr,
//    Act, Chk, Pos; read Move, Addr, Act, RdWait, Pos; clear Move, a blank
//    fill of every cell, Pos. A put past the last row adds a scroll copy up
//    one row and a last-row blank fill; the single-port-write cell store,
//    one cell per cycle, sets these sweeps.
//  - After reset the store is swept to 0x0F blanks with in_stall_o high.
//  - While out_stall_i is high the result word holds and no input is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit #(
  parameter int unsigned Columns = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned Rows    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [tcw_pkg::OP_W-1:0]   op_i,
  input  wire logic [tcw_pkg::BYTE_W-1:0] char_code_i,
  input  wire logic [tcw_pkg::COL_FW-1:0] col_i,
  input  wire logic [tcw_pkg::ROW_FW-1:0] row_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [tcw_pkg::BYTE_W-1:0] read_char_o,
  output logic      [tcw_pkg::BYTE_W-1:0] read_attr_o,
  output logic      [tcw_pkg::COL_FW-1:0] cursor_col_o,
  output logic      [tcw_pkg::ROW_FW-1:0] cursor_row_o,
  output logic      [tcw_pkg::POS_FW-1:0] cursor_pos_o
);
  import tcw_pkg::*;

  localparam int unsigned Cells = Columns * Rows;
  localparam int unsigned AddrW = $clog2(Cells);

  logic [BYTE_W-1:0] text_attr_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [AddrW-1:0]  mem_raddr;
  cell_t             mem_wdata;
  cell_t             mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      text_attr_q <= cfg_wdata_i;
    end
  end

  tcw_seq #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .text_attr_i  (text_attr_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cursor_pos_o (cursor_pos_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tcw_cell_ram #(
    .Depth (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a pending result keeps the input side closed
  a_busy_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result word waits");

  // an accepted word never produces a result in the very next cycle
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("input not closed after acceptance");

  a_cursor_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_col_o) < Columns))
    else $error("cursor column beyond right edge");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for text_console_writer_unit (80 x 25 console).
// Depends on tcw_pkg and text_console_writer_unit; a shadow screen predicts each result word.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int unsigned COLS        = DEF_COLUMNS;
  localparam int unsigned ROWS        = DEF_ROWS;
  localparam int unsigned CELLS       = COLS * ROWS;
  localparam int unsigned PHASE_WORDS = 400;
  localparam int unsigned HOLD_AT     = 600;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CALM_FROM   = 1000;
  localparam int unsigned CALM_TO     = 1300;
  localparam int unsigned IDLE_PCT    = 21;
  localparam int unsigned TAIL_CYCLES = 2 * CELLS + COLS + 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] code;
    logic [COL_FW-1:0] col;
    logic [ROW_FW-1:0] row;
  } console_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_char;
    logic [BYTE_W-1:0] rd_attr;
    logic [COL_FW-1:0] cur_col;
    logic [ROW_FW-1:0] cur_row;
    logic [POS_FW-1:0] cur_pos;
  } console_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic [OP_W-1:0] op = '0;
  logic [BYTE_W-1:0] char_code = '0;
  logic [COL_FW-1:0] col = '0;
  logic [ROW_FW-1:0] row = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;
  logic [COL_FW-1:0] cursor_col;
  logic [ROW_FW-1:0] cursor_row;
  logic [POS_FW-1:0] cursor_pos;

  console_cmd_t  pending_cmds[$];
  console_view_t expected_views[$];

  // shadow console state
  cell_t         screen_img[CELLS];
  logic [7:0]    shadow_attr = RESET_ATTR;
  int unsigned   shadow_col = 0;
  int unsigned   shadow_row = 0;

  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned n_put = 0, n_read = 0, n_clear = 0, n_set = 0, n_scroll = 0, n_attr = 0;
  int unsigned sent = 0;
  int unsigned rx_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_budget = 50000;

  text_console_writer_unit #(
    .Columns(COLS),
    .Rows   (ROWS)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .char_code_i (char_code),
    .col_i       (col),
    .row_i       (row),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_char_o (read_char),
    .read_attr_o (read_attr),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row),
    .cursor_pos_o(cursor_pos)
  );

  always #1 clk = ~clk;

  initial begin
    foreach (screen_img[i]) screen_img[i] = '{attr: RESET_ATTR, code: BLANK_CHAR};
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
    return (v < lim) ? v : lim - 1;
  endfunction

  // Applies one command to the shadow console; returns the result word it should produce.
  // swept reports whether the command walked the whole store.
  function automatic console_view_t apply_cmd(console_cmd_t c, output bit swept);
    console_view_t v;
    int unsigned   idx;
    swept = 1'b0;
    v = '0;
    case (c.op)
      OP_PUT: begin
        n_put++;
        case (c.code)
          CH_NL: begin
            shadow_col = 0;
            shadow_row++;
          end
          CH_CR: shadow_col = 0;
          CH_TAB: begin
            shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
            if (shadow_col >= COLS) begin
              shadow_col = 0;
              shadow_row++;
            end
          end
          CH_BS: begin
            if (shadow_col > 0) begin
              shadow_col--;
            end else if (shadow_row > 0) begin
              shadow_row--;
              shadow_col = COLS - 1;
            end
            screen_img[shadow_row * COLS + shadow_col] = '{attr: shadow_attr, code: BLANK_CHAR};
          end
          default: begin
            screen_img[shadow_row * COLS + shadow_col] = '{attr: shadow_attr, code: c.code};
            shadow_col++;
            if (shadow_col >= COLS) begin
              shadow_col = 0;
              shadow_row++;
            end
          end
        endcase
        if (shadow_row >= ROWS) begin
          for (int unsigned i = 0; i < (ROWS - 1) * COLS; i++) screen_img[i] = screen_img[i + COLS];
          for (int unsigned i = (ROWS - 1) * COLS; i < CELLS; i++)
            screen_img[i] = '{attr: shadow_attr, code: BLANK_CHAR};
          shadow_row = ROWS - 1;
          n_scroll++;
          swept = 1'b1;
        end
      end
      OP_READ: begin
        n_read++;
        idx = clamp_to(c.row, ROWS) * COLS + clamp_to(c.col, COLS);
        v.rd_char = screen_img[idx].code;
        v.rd_attr = screen_img[idx].attr;
      end
      OP_CLEAR: begin
        n_clear++;
        foreach (screen_img[i]) screen_img[i] = '{attr: shadow_attr, code: BLANK_CHAR};
        shadow_col = 0;
        shadow_row = 0;
        swept = 1'b1;
      end
      default: begin
        n_set++;
        shadow_col = clamp_to(c.col, COLS);
        shadow_row = clamp_to(c.row, ROWS);
      end
    endcase
    v.cur_col = shadow_col[COL_FW-1:0];
    v.cur_row = shadow_row[ROW_FW-1:0];
    v.cur_pos = POS_FW'(shadow_row * COLS + shadow_col);
    return v;
  endfunction

  // Driver: next word goes out once the current one is taken, with random gaps.
  always @(posedge clk) begin
    console_cmd_t c;
    bit           calm;
    calm = (sent >= CALM_FROM) && (sent < CALM_TO);
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        c = pending_cmds.pop_front();
        in_valid  <= 1'b1;
        op        <= c.op;
        char_code <= c.code;
        col       <= c.col;
        row       <= c.row;
        sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, one long hold, and a calm stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) rx_taken++;
      if (rx_taken == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_taken >= CALM_FROM && rx_taken < CALM_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic report_mismatch(string what, console_view_t want, console_view_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp char=%02h attr=%02h col=%0d row=%0d pos=%0d | got char=%02h attr=%02h col=%0d row=%0d pos=%0d",
               $realtime, what, want.rd_char, want.rd_attr, want.cur_col, want.cur_row,
               want.cur_pos, got.rd_char, got.rd_attr, got.cur_col, got.cur_row, got.cur_pos);
  endtask

  // Monitor: shadows config writes, predicts on acceptance, checks result words.
  always @(posedge clk) begin
    console_view_t want;
    console_view_t got;
    bit            swept;
    if (rst_n) begin
      if (cfg_we) begin
        shadow_attr = cfg_wdata;
        n_attr++;
      end
      if (in_valid && !in_stall) begin
        expected_views.push_back(apply_cmd('{op, char_code, col, row}, swept));
        cycle_budget <= cycle_budget + 400 + (swept ? 4 * (2 * CELLS + COLS) : 0);
      end
      if (out_valid && !out_stall) begin
        got = '{read_char, read_attr, cursor_col, cursor_row, cursor_pos};
        words_checked++;
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected word", '0, got);
        end else begin
          want = expected_views.pop_front();
          if (got !== want) report_mismatch("word mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_views.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_cmd(logic [OP_W-1:0] o, logic [BYTE_W-1:0] ch, int unsigned c,
                          int unsigned r);
    pending_cmds.push_back('{o, ch, COL_FW'(c), ROW_FW'(r)});
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attr(logic [BYTE_W-1:0] a);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly text with some control codes; cursor sets lean toward the bottom to force scrolls.
  task automatic push_random_words(int unsigned count);
    int unsigned       pick;
    logic [BYTE_W-1:0] ch;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 19))
          0: ch = CH_NL;
          1: ch = CH_CR;
          2: ch = CH_TAB;
          3: ch = CH_BS;
          default: ch = $urandom_range(0, 255);
        endcase
        push_cmd(OP_PUT, ch, $urandom_range(0, 127), $urandom_range(0, 31));
      end else if (pick < 86) begin
        push_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 31));
      end else if (pick < 98) begin
        push_cmd(OP_SET, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(20, 31));
      end else begin
        push_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 31));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] attr_plan[5];
    attr_plan = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00};
    attr_plan[2] = $urandom_range(0, 255);
    attr_plan[4] = $urandom_range(0, 255);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, printable extremes, control codes, wraps, scrolls, clamps
    push_cmd(OP_READ, 8'h00, 0, 0);
    push_cmd(OP_PUT, 8'h41, 0, 0);
    push_cmd(OP_PUT, 8'hFF, 127, 31);
    push_cmd(OP_PUT, 8'h00, 0, 0);
    push_cmd(OP_READ, 8'h00, 0, 0);
    push_cmd(OP_PUT, CH_TAB, 0, 0);
    push_cmd(OP_PUT, CH_CR, 0, 0);
    push_cmd(OP_PUT, CH_NL, 0, 0);
    push_cmd(OP_PUT, CH_BS, 0, 0);           // crosses back to end of row 0
    push_cmd(OP_READ, 8'h00, 79, 0);
    push_cmd(OP_SET, 8'h00, 0, 0);
    push_cmd(OP_PUT, CH_BS, 0, 0);           // backspace at origin
    push_cmd(OP_SET, 8'hFF, 127, 31);        // clamped to bottom-right
    push_cmd(OP_PUT, 8'h5A, 0, 0);           // wrap off the last cell scrolls
    push_cmd(OP_READ, 8'h00, 127, 31);
    push_cmd(OP_READ, 8'h00, 127, 23);
    push_cmd(OP_SET, 8'h00, 75, 24);
    push_cmd(OP_PUT, CH_TAB, 0, 0);          // tab wraps and scrolls
    push_cmd(OP_SET, 8'h00, 0, 24);
    push_cmd(OP_PUT, CH_NL, 0, 0);
    push_cmd(OP_SET, 8'h00, 79, 10);
    push_cmd(OP_PUT, 8'h7F, 0, 0);
    push_cmd(OP_CLEAR, 8'h00, 0, 0);
    push_cmd(OP_READ, 8'h00, 79, 24);
    push_cmd(OP_SET, 8'h00, 4, 2);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_attr(attr_plan[p]);
      push_random_words(PHASE_WORDS);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_views.size() != 0) begin
      $display("%0d expected words never arrived", expected_views.size());
      mismatch_count += expected_views.size();
    end

    $display("Checked %0d words: %0d puts, %0d reads, %0d clears, %0d cursor sets, %0d scrolls",
             words_checked, n_put, n_read, n_clear, n_set, n_scroll);
    $display("Attribute writes: %0d, long output hold: %0d cycles, mismatches: %0d",
             n_attr, HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tcw_pkg.sv
hdl/tcw_lin_unit.sv
hdl/tcw_cell_ram.sv
hdl/tcw_seq.sv
hdl/text_console_writer_unit.sv
sim/tb_top.sv
